FILE: rtl/sha1md_pkg.sv
// ----------------------------------------------------------------------------
// sha1md_pkg
// shared types, constants and round functions for the sha-1 digest block
// ----------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

   // input transaction
   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  byte_count;
      logic        last_word;
   } req_type;

   // result transaction
   typedef struct packed {
      logic [63:0] digest_upper;
      logic [63:0] digest_middle;
      logic [31:0] digest_lower;
   } rsp_type;

   // five chaining words, index 0 is h0
   typedef logic [4:0][31:0] chain_type;

   localparam chain_type IV_VALUE = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                     32'hefcdab89, 32'h67452301};

   localparam logic [7:0]  PAD_MARK   = 8'h80;
   localparam logic [6:0]  LAST_ROUND = 7'd79;
   localparam logic [3:0]  LAST_FILL  = 4'd15;
   localparam logic [3:0]  LEN_FILL   = 4'd14;
   localparam logic [2:0]  FULL_COUNT = 3'd4;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MARK,
      ST_ZERO,
      ST_LEN_LO,
      ST_COMP,
      ST_FINISH
   } state_type;

   // commands to the compression core
   typedef struct packed {
      logic start;
      logic init;
   } core_cmd_type;

   // status from the compression core
   typedef struct packed {
      logic run;
      logic done;
      logic busy;
   } core_sts_type;

   // commands to the message schedule
   typedef struct packed {
      logic push;
      logic advance;
   } sched_cmd_type;

   function automatic logic [31:0] round_const(input logic [6:0] rnd);
      logic [31:0] k;
      if (rnd < 7'd20) begin
         k = 32'h5a827999;
      end else if (rnd < 7'd40) begin
         k = 32'h6ed9eba1;
      end else if (rnd < 7'd60) begin
         k = 32'h8f1bbcdc;
      end else begin
         k = 32'hca62c1d6;
      end
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0]  rnd,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
      logic [31:0] f;
      if (rnd < 7'd20) begin
         f = ((c ^ d) & b) ^ d;
      end else if (rnd < 7'd40) begin
         f = b ^ c ^ d;
      end else if (rnd < 7'd60) begin
         f = (b & c) | (b & d) | (c & d);
      end else begin
         f = b ^ c ^ d;
      end
      return f;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/sha1md_sched.sv
// ----------------------------------------------------------------------------
// sha1md_sched
// 16-word block buffer as a shift line; expands the message schedule in place
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_sched (
   input  wire logic                     clock,
   input  wire sha1md_pkg::sched_cmd_type sched_cmd,
   input  wire logic [31:0]              push_data,
   output logic [31:0]                   sched_word
);

   logic [15:0][31:0] buf_ff;
   logic [15:0][31:0] buf_in;
   logic [31:0]       mix;
   logic [31:0]       new_word;

   // buf_ff[k] holds w[r+k] during round r
   always_comb begin
      mix      = buf_ff[13] ^ buf_ff[8] ^ buf_ff[2] ^ buf_ff[0];
      new_word = sched_cmd.push ? push_data : {mix[30:0], mix[31]};
      buf_in   = {new_word, buf_ff[15:1]};
   end

   always_ff @(posedge clock) begin
      if (sched_cmd.push || sched_cmd.advance) begin
         buf_ff <= buf_in;
      end
   end

   assign sched_word = buf_ff[0];

endmodule

`default_nettype wire

FILE: rtl/sha1md_core.sv
// ----------------------------------------------------------------------------
// sha1md_core
// shared round unit: one sha-1 round per cycle, then chaining value update
// ----------------------------------------------------------------------------
`default_nettype none

module sha1md_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sha1md_pkg::core_cmd_type core_cmd,
   input  wire logic [31:0]             sched_word,
   output sha1md_pkg::core_sts_type     core_sts,
   output sha1md_pkg::chain_type        chain
);

   sha1md_pkg::chain_type chain_ff, chain_in;
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] a_in, b_in, c_in, d_in, e_in;
   logic [6:0]  round_ff, round_in;
   logic        run_ff, run_in;
   logic        add_ff, add_in;
   logic [31:0] temp;

   always_comb begin
      temp = {a_ff[26:0], a_ff[31:27]}
           + sha1md_pkg::round_f(round_ff, b_ff, c_ff, d_ff)
           + e_ff + sched_word + sha1md_pkg::round_const(round_ff);

      a_in     = a_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      d_in     = d_ff;
      e_in     = e_ff;
      round_in = round_ff;
      run_in   = run_ff;
      add_in   = 1'b0;
      chain_in = chain_ff;

      if (core_cmd.start) begin
         a_in     = chain_ff[0];
         b_in     = chain_ff[1];
         c_in     = chain_ff[2];
         d_in     = chain_ff[3];
         e_in     = chain_ff[4];
         round_in = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         a_in     = temp;
         b_in     = a_ff;
         c_in     = {b_ff[1:0], b_ff[31:2]};
         d_in     = c_ff;
         e_in     = d_ff;
         round_in = round_ff + 7'd1;
         if (round_ff == sha1md_pkg::LAST_ROUND) begin
            run_in = 1'b0;
            add_in = 1'b1;
         end
      end

      // feed-forward add after the last round
      if (add_ff) begin
         chain_in[0] = chain_ff[0] + a_ff;
         chain_in[1] = chain_ff[1] + b_ff;
         chain_in[2] = chain_ff[2] + c_ff;
         chain_in[3] = chain_ff[3] + d_ff;
         chain_in[4] = chain_ff[4] + e_ff;
      end else if (core_cmd.init) begin
         chain_in = sha1md_pkg::IV_VALUE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         add_ff   <= 1'b0;
         round_ff <= '0;
         chain_ff <= sha1md_pkg::IV_VALUE;
      end else begin
         run_ff   <= run_in;
         add_ff   <= add_in;
         round_ff <= round_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   assign core_sts.run  = run_ff;
   assign core_sts.done = add_ff;
   assign core_sts.busy = run_ff | add_ff;
   assign chain         = chain_ff;

endmodule

`default_nettype wire

FILE: rtl/sha1_message_digest.sv
// ----------------------------------------------------------------------------
// sha1_message_digest
// sha-1 hash of a byte message delivered as big-endian 32-bit words
// ----------------------------------------------------------------------------
// a word that does not complete a 16-word block is only pushed into the schedule buffer
// a word that completes a block is pushed, then waits for the 80 rounds and the chaining add
// after the last word, padding pushes one word per cycle while no block is being compressed;
// the digest goes to rsp after the final chaining add, via finish and the result register
// the single round unit sets the pace: no word is taken while a block is compressed
// reset is synchronous active high: chaining words to initial values, counts cleared
`default_nettype none

module sha1_message_digest (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire sha1md_pkg::req_type req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output sha1md_pkg::rsp_type      rsp_data
);

   // sequencer state and the state to resume after a compression
   sha1md_pkg::state_type state_ff, state_in;
   sha1md_pkg::state_type ret_ff, ret_in;
   sha1md_pkg::state_type after;

   logic [3:0]  fill_ff, fill_in;       // next free word of the block
   logic [63:0] bitlen_ff, bitlen_in;   // message length in bits, wraps
   logic        rsp_valid_ff, rsp_valid_in;
   sha1md_pkg::rsp_type rsp_data_ff, rsp_data_in;

   sha1md_pkg::core_cmd_type  core_cmd;
   sha1md_pkg::core_sts_type  core_sts;
   sha1md_pkg::sched_cmd_type sched_cmd;
   sha1md_pkg::chain_type     chain;

   logic        push;
   logic [31:0] push_data;
   logic [31:0] sched_word;
   logic [2:0]  count_c;
   logic [31:0] masked_word;
   logic [31:0] marker_word;
   logic [5:0]  len_add;
   logic        accept;

   assign accept = req_valid && req_ready;

   // byte count saturates at four
   always_comb begin
      count_c = (req_data.byte_count > sha1md_pkg::FULL_COUNT) ?
                sha1md_pkg::FULL_COUNT : req_data.byte_count;
      len_add = req_data.last_word ? {count_c, 3'b000} : 6'd32;
   end

   // mask of the unused trailing bytes and the pad marker right after the data
   always_comb begin
      case (count_c)
         3'd0: begin
            masked_word = 32'h0;
            marker_word = {sha1md_pkg::PAD_MARK, 24'h0};
         end
         3'd1: begin
            masked_word = {req_data.message_word[31:24], 24'h0};
            marker_word = {8'h0, sha1md_pkg::PAD_MARK, 16'h0};
         end
         3'd2: begin
            masked_word = {req_data.message_word[31:16], 16'h0};
            marker_word = {16'h0, sha1md_pkg::PAD_MARK, 8'h0};
         end
         3'd3: begin
            masked_word = {req_data.message_word[31:8], 8'h0};
            marker_word = {24'h0, sha1md_pkg::PAD_MARK};
         end
         default: begin
            masked_word = req_data.message_word;
            marker_word = 32'h0;
         end
      endcase
   end

   // sequencer: loads words, generates the padding, waits on compressions, hands off the digest
   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      after        = state_ff;
      fill_in      = fill_ff;
      bitlen_in    = bitlen_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      push         = 1'b0;
      push_data    = 32'h0;
      core_cmd     = '0;
      req_ready    = 1'b0;

      // result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sha1md_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               push      = 1'b1;
               bitlen_in = bitlen_ff + {58'h0, len_add};
               if (req_data.last_word) begin
                  push_data = masked_word | marker_word;
                  after     = (count_c == sha1md_pkg::FULL_COUNT) ?
                              sha1md_pkg::ST_MARK : sha1md_pkg::ST_ZERO;
               end else begin
                  push_data = req_data.message_word;
                  after     = sha1md_pkg::ST_IDLE;
               end
            end
         end
         sha1md_pkg::ST_MARK: begin
            // full last word: marker goes in a word of its own
            push      = 1'b1;
            push_data = {sha1md_pkg::PAD_MARK, 24'h0};
            after     = sha1md_pkg::ST_ZERO;
         end
         sha1md_pkg::ST_ZERO: begin
            push = 1'b1;
            if (fill_ff == sha1md_pkg::LEN_FILL) begin
               push_data = bitlen_ff[63:32];
               after     = sha1md_pkg::ST_LEN_LO;
            end else begin
               push_data = 32'h0;
               after     = sha1md_pkg::ST_ZERO;
            end
         end
         sha1md_pkg::ST_LEN_LO: begin
            push      = 1'b1;
            push_data = bitlen_ff[31:0];
            after     = sha1md_pkg::ST_FINISH;
         end
         sha1md_pkg::ST_COMP: begin
            if (core_sts.done) begin
               state_in = ret_ff;
            end
         end
         sha1md_pkg::ST_FINISH: begin
            // hand off the digest once the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.digest_upper    = {chain[0], chain[1]};
               rsp_data_in.digest_middle   = {chain[2], chain[3]};
               rsp_data_in.digest_lower    = chain[4];
               core_cmd.init               = 1'b1;
               bitlen_in                   = 64'h0;
               state_in                    = sha1md_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sha1md_pkg::ST_IDLE;
         end
      endcase

      // every push advances the fill; the sixteenth starts a compression
      if (push) begin
         fill_in = fill_ff + 4'd1;
         if (fill_ff == sha1md_pkg::LAST_FILL) begin
            core_cmd.start = 1'b1;
            ret_in         = after;
            state_in       = sha1md_pkg::ST_COMP;
         end else begin
            state_in = after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sha1md_pkg::ST_IDLE;
         ret_ff       <= sha1md_pkg::ST_IDLE;
         fill_ff      <= '0;
         bitlen_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         fill_ff      <= fill_in;
         bitlen_ff    <= bitlen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // schedule shifts on each push and on each running round
   always_comb begin
      sched_cmd.push    = push;
      sched_cmd.advance = core_sts.run;
   end

   sha1md_sched u_sched (
      .clock      (clock),
      .sched_cmd  (sched_cmd),
      .push_data  (push_data),
      .sched_word (sched_word)
   );

   sha1md_core u_core (
      .clock      (clock),
      .reset      (reset),
      .core_cmd   (core_cmd),
      .sched_word (sched_word),
      .core_sts   (core_sts),
      .chain      (chain)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no transaction is taken while the round unit is working
   a_idle_core: assert property (@(posedge clock) disable iff (reset)
      accept |-> !core_sts.busy)
      else $error("input transaction accepted during compression");

   // a compression start is followed by running rounds
   a_start_run: assert property (@(posedge clock) disable iff (reset)
      core_cmd.start |=> core_sts.run)
      else $error("compression start did not run rounds");

   // the digest is only taken at a block boundary
   a_finish_fill: assert property (@(posedge clock) disable iff (reset)
      state_ff == sha1md_pkg::ST_FINISH |-> fill_ff == 4'd0)
      else $error("digest taken with a partial block");

   // the chaining add only happens while waiting for a compression
   a_done_comp: assert property (@(posedge clock) disable iff (reset)
      core_sts.done |-> state_ff == sha1md_pkg::ST_COMP)
      else $error("chaining add outside of compression wait");

endmodule

`default_nettype wire
